### rtl/core/assert_macros.svh
// assertion helpers, included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define TRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be true outside reset
`define TRS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define TRS_ASSERT(label, clk, rst_n, prop)
`define TRS_NEVER(label, clk, rst_n, cond)
`endif
`endif

### rtl/core/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared constants, codes and the Lanczos-3 phase table of the resampler.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int TRACE_DEPTH_DEF = 4096;
    localparam int SINC_PHASES     = 64;
    localparam int MAX_TAPS        = 6;
    localparam int PH_BITS         = $clog2(SINC_PHASES);

    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 12;
    localparam int OIDX_W   = 16;
    localparam int CFG_W    = 32;
    localparam int CIDX_W   = 2;
    localparam int WGT_W    = 18;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 40;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_START = 2'd2;
    localparam logic [CIDX_W-1:0] REG_STEP  = 2'd3;

    // kernel codes
    localparam logic [1:0] MODE_LIN = 2'd0;
    localparam logic [1:0] MODE_BSP = 2'd1;
    localparam logic [1:0] MODE_LZ  = 2'd2;

    // ceil(2^19 / 3), exact floor(y / 3) for y below 2^17 and a bit more
    localparam logic [17:0] RECIP3 = 18'd174763;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef logic signed [WGT_W-1:0] lz_tab_t [SINC_PHASES*MAX_TAPS];

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_en;
    } mac_ctl_t;

    // shift-subtract divide, used only while the table is built
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // {sign, |sin(pi*a/65536)| in Q30}
    function automatic logic [64:0] sin_mag(logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] h;
        logic        neg;
        a   = a_in & 64'h1FFFF;
        neg = 1'b0;
        if (a >= 64'h10000) begin
            neg = 1'b1;
            a   = a - 64'h10000;
        end
        if (a > 64'h8000) a = 64'h10000 - a;
        t  = (a * PI_Q30) >> 16;
        t2 = (t * t) >> 30;
        h  = ONE_Q30 - t2 / 110;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 72;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 42;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 20;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 6;
        return {neg, (t * h) >> 30};
    endfunction

    // sinc of a non-negative Q16 argument, signed Q30
    function automatic logic signed [63:0] sinc_q30(logic [63:0] a);
        logic [64:0] sm;
        logic [63:0] pix;
        logic [63:0] q;
        if (a == 64'd0) return $signed(ONE_Q30);
        sm  = sin_mag(a);
        pix = (a * PI_Q30) >> 16;
        q   = udiv64(sm[63:0] << 30, pix);
        return sm[64] ? -$signed(q) : $signed(q);
    endfunction

    function automatic lz_tab_t build_lz();
        lz_tab_t             tab;
        logic signed [63:0]  xq;
        logic signed [63:0]  prod;
        logic [63:0]         ax;
        int                  dq;
        for (int p = 0; p < SINC_PHASES; p++) begin
            dq = (p * 65536) / SINC_PHASES;
            for (int i = 0; i < MAX_TAPS; i++) begin
                xq   = 64'((2 - i) * 65536 + dq);
                ax   = (xq < 0) ? 64'(-xq) : 64'(xq);
                prod = sinc_q30(ax) * sinc_q30(ax / 3);
                tab[p*MAX_TAPS+i] = WGT_W'((prod + (64'sd1 <<< 43)) >>> 44);
            end
        end
        return tab;
    endfunction

    localparam lz_tab_t LZ_TAB = build_lz();

endpackage

### rtl/core/trs_if.sv
// ----------------------------------------------------------------------------
// trs_req_if / trs_rsp_if
// Valid-ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface trs_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic [trs_pkg::IDX_W-1:0]             sample_index;
    logic signed [trs_pkg::SAMPLE_W-1:0]   sample_value;
    logic [trs_pkg::OIDX_W-1:0]            out_index;

    modport source (output valid, req_type, sample_index, sample_value, out_index,
                    input ready);
    modport sink (input valid, req_type, sample_index, sample_value, out_index,
                  output ready);
endinterface

interface trs_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [trs_pkg::SAMPLE_W-1:0]   out_value;
    logic                                  out_of_range;

    modport source (output valid, out_value, out_of_range, input ready);
    modport sink (input valid, out_value, out_of_range, output ready);
endinterface

### rtl/core/trs_ram.sv
// ----------------------------------------------------------------------------
// trs_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module trs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/trs_mac.sv
// ----------------------------------------------------------------------------
// trs_mac
// Shared signed multiplier with registered product and an accumulator.
// ----------------------------------------------------------------------------
module trs_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  trs_pkg::mac_ctl_t                    ctl,
    input  logic signed [trs_pkg::MUL_W-1:0]     a,
    input  logic signed [trs_pkg::MUL_W-1:0]     b,
    output logic signed [trs_pkg::PROD_W-1:0]    prod,
    output logic signed [trs_pkg::ACC_W-1:0]     acc
);

    logic signed [trs_pkg::PROD_W-1:0] prod_reg;
    logic signed [trs_pkg::ACC_W-1:0]  acc_reg;
    logic signed [trs_pkg::ACC_W-1:0]  acc_next;

    // accumulate the low part of the last product
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.acc_clr)
            acc_next = '0;
        else if (ctl.acc_en)
            acc_next = acc_reg + prod_reg[trs_pkg::ACC_W-1:0];
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= a * b;
        end
    end

    // accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

### rtl/core/trace_resampler_lin_bspline_sinc_top.sv
// ----------------------------------------------------------------------------
// trace_resampler_lin_bspline_sinc_top
// Trace resampler with linear, cubic B-spline and Lanczos-3 kernels.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per item: req_type 0 writes sample_value into the
//   trace store at sample_index, req_type 1 asks for output sample out_index.
//   rsp carries one word per read request: the resampled value and the
//   out_of_range flag. Writes produce no word. Registers (mode, in_count,
//   start_pos, step_ratio) are written through cfg_we / cfg_index / cfg_data;
//   the user must do so only while the block is idle; the block does not check.
// Timing:
//   a write leaves req ready. A read holds off req until its result word is
//   valid, longest with the B-spline, shorter with Lanczos-3 and shortest with
//   the linear kernel, and less still when the window leaves the trace; the next
//   word is taken in the cycle in which the result word becomes valid. A read is
//   held this long by the single shared multiplier, which forms the position, the
//   B-spline powers and three of the four weights, and every tap product, and by
//   one store read per tap.
// Reset clears the registers to mode 0, in_count 4096, start_pos 0 and
// step_ratio 1.0; the store holds nothing until written. A finished word
// waits in the output register while rsp stalls; new items are taken, but
// the next read result waits until that word has left.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trace_resampler_lin_bspline_sinc_top #(
    parameter int TRACE_DEPTH = trs_pkg::TRACE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    trs_req_if.sink                           req,
    trs_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [trs_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [trs_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW       = $clog2(TRACE_DEPTH);
    localparam int W        = trs_pkg::WGT_W;
    localparam int MW       = trs_pkg::MUL_W;
    localparam int PH_SEL_W = trs_pkg::PH_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_POS, S_CHK, S_BG2, S_BG3, S_BF2, S_BF3,
        S_BW0, S_BW1, S_BW2, S_BW3, S_TAP, S_RND
    } state_t;

    state_t                         state_reg;
    logic [1:0]                     mode_reg;
    logic [12:0]                    count_reg;
    logic [31:0]                    start_reg;
    logic [31:0]                    step_reg;

    logic [trs_pkg::OIDX_W-1:0]     j_reg;
    logic [15:0]                    f_reg;
    logic [AW-1:0]                  lo_reg;
    logic [2:0]                     tap_n_reg;
    logic [2:0]                     k_reg;
    logic [2:0]                     k1_reg;
    logic                           v1_reg;
    logic                           v2_reg;
    logic                           oor_reg;
    logic [32:0]                    g2_reg;
    logic [48:0]                    g3_reg;
    logic [32:0]                    f2_reg;
    logic [48:0]                    f3_reg;
    logic signed [W-1:0]            w_reg [trs_pkg::MAX_TAPS];

    logic                           out_valid_reg;
    logic signed [15:0]             out_value_reg;
    logic                           out_oor_reg;

    trs_pkg::mac_ctl_t              mac_ctl;
    logic signed [MW-1:0]           mul_a;
    logic signed [MW-1:0]           mul_b;
    logic signed [trs_pkg::PROD_W-1:0] prod;
    logic signed [trs_pkg::ACC_W-1:0]  acc;

    logic                           ram_we;
    logic                           ram_re;
    logic [AW-1:0]                  ram_waddr;
    logic [AW-1:0]                  ram_raddr;
    logic [15:0]                    ram_rdata;
    logic [31:0]                    widx;

    logic signed [49:0]             pos;
    logic signed [35:0]             base;
    logic signed [35:0]             lo;
    logic signed [35:0]             hi;
    logic [1:0]                     pad;
    logic [17:0]                    cnt;
    logic                           win_out;
    logic [16:0]                    g;
    logic [18:0]                    y0;
    logic [18:0]                    y1;
    logic [18:0]                    y2;
    logic [51:0]                    nf;
    logic [51:0]                    ng;
    logic [PH_SEL_W-1:0]            phase;
    logic signed [23:0]             rnd;
    logic signed [15:0]             sat;
    logic                           req_acc;
    logic                           rsp_free;

    assign req_acc  = req.valid && req.ready;
    assign rsp_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= trs_pkg::MODE_LIN;
            count_reg <= 13'd4096;
            start_reg <= '0;
            step_reg  <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trs_pkg::REG_MODE:  mode_reg  <= cfg_data[1:0];
                trs_pkg::REG_COUNT: count_reg <= cfg_data[12:0];
                trs_pkg::REG_START: start_reg <= cfg_data;
                trs_pkg::REG_STEP:  step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // position, window and kernel parameters
    always_comb
    begin
        pos   = 50'($signed(start_reg)) + $signed({2'b00, prod[47:0]});
        base  = 36'($signed(pos[49:16]));
        case (mode_reg)
            trs_pkg::MODE_BSP: pad = 2'd2;
            trs_pkg::MODE_LZ:  pad = 2'd3;
            default:           pad = 2'd1;
        endcase
        lo    = base - $signed(36'(pad - 2'd1));
        hi    = base + $signed(36'(pad));
        cnt   = (18'(count_reg) > 18'(TRACE_DEPTH)) ? 18'(TRACE_DEPTH) : 18'(count_reg);
        win_out = (lo < 0) || (hi > $signed(36'(cnt)) - 36'sd1);
        phase = pos[15 -: PH_SEL_W];
        g     = 17'h10000 - 17'(f_reg);
        y0    = 19'((50'(g3_reg) + (50'd3 << 32)) >> 33);
        nf    = (52'd4 << 48) + 52'(f3_reg) + (52'(f3_reg) << 1) + (52'd3 << 32)
                - ((52'(f2_reg) << 2) + (52'(f2_reg) << 1) << 16);
        ng    = (52'd4 << 48) + 52'(g3_reg) + (52'(g3_reg) << 1) + (52'd3 << 32)
                - ((52'(g2_reg) << 2) + (52'(g2_reg) << 1) << 16);
        y1    = nf[51:33];
        y2    = ng[51:33];
        rnd   = 24'((acc + 40'sd32768) >>> 16);
        if (rnd > 24'sd32767)
            sat = 16'sh7fff;
        else if (rnd < -24'sd32768)
            sat = -16'sh8000;
        else
            sat = rnd[15:0];
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        mac_ctl = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_POS:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a = $signed(MW'(j_reg));
                mul_b = $signed(MW'(step_reg));
            end
            S_CHK: mac_ctl.acc_clr = 1'b1;
            S_BG2:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a = $signed(MW'(g));
                mul_b = $signed(MW'(g));
            end
            S_BG3:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a = $signed(MW'(prod[32:0]));
                mul_b = $signed(MW'(g));
            end
            S_BF2:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a = $signed(MW'(f_reg));
                mul_b = $signed(MW'(f_reg));
            end
            S_BF3:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a = $signed(MW'(prod[32:0]));
                mul_b = $signed(MW'(f_reg));
            end
            S_BW0:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a = $signed(MW'(y0));
                mul_b = $signed(MW'(trs_pkg::RECIP3));
            end
            S_BW1:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a = $signed(MW'(y1));
                mul_b = $signed(MW'(trs_pkg::RECIP3));
            end
            S_BW2:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a = $signed(MW'(y2));
                mul_b = $signed(MW'(trs_pkg::RECIP3));
            end
            S_TAP:
            begin
                mac_ctl.mul_en = v1_reg;
                mac_ctl.acc_en = v2_reg;
                mul_a = MW'(w_reg[k1_reg]);
                mul_b = MW'($signed(ram_rdata));
            end
            default: ;
        endcase
    end

    // store ports
    assign widx      = 32'(req.sample_index);
    assign ram_we    = req_acc && !req.req_type && (widx < 32'(TRACE_DEPTH));
    assign ram_waddr = widx[AW-1:0];
    assign ram_re    = (state_reg == S_TAP) && (k_reg < tap_n_reg);
    assign ram_raddr = lo_reg + AW'(k_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            k_reg         <= '0;
            k1_reg        <= '0;
            tap_n_reg     <= '0;
            oor_reg       <= 1'b0;
        end
        else
        begin
            // output word valid flag
            if ((state_reg == S_RND) && rsp_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_acc && req.req_type)
                    begin
                        j_reg     <= req.out_index;
                        state_reg <= S_POS;
                    end
                end
                S_POS: state_reg <= S_CHK;
                S_CHK:
                begin
                    f_reg     <= pos[15:0];
                    lo_reg    <= lo[AW-1:0];
                    tap_n_reg <= {pad, 1'b0};
                    oor_reg   <= win_out;
                    k_reg     <= '0;
                    v1_reg    <= 1'b0;
                    v2_reg    <= 1'b0;
                    if (win_out)
                        state_reg <= S_RND;
                    else if (mode_reg == trs_pkg::MODE_BSP)
                        state_reg <= S_BG2;
                    else
                    begin
                        if (mode_reg == trs_pkg::MODE_LZ)
                        begin
                            for (int i = 0; i < trs_pkg::MAX_TAPS; i++)
                                w_reg[i] <= trs_pkg::LZ_TAB[int'(phase)*trs_pkg::MAX_TAPS+i];
                        end
                        else
                        begin
                            w_reg[0] <= W'(18'h10000 - 18'(pos[15:0]));
                            w_reg[1] <= W'(pos[15:0]);
                        end
                        state_reg <= S_TAP;
                    end
                end
                S_BG2: state_reg <= S_BG3;
                S_BG3:
                begin
                    g2_reg    <= prod[32:0];
                    state_reg <= S_BF2;
                end
                S_BF2:
                begin
                    g3_reg    <= prod[48:0];
                    state_reg <= S_BF3;
                end
                S_BF3:
                begin
                    f2_reg    <= prod[32:0];
                    state_reg <= S_BW0;
                end
                S_BW0:
                begin
                    f3_reg    <= prod[48:0];
                    state_reg <= S_BW1;
                end
                S_BW1:
                begin
                    w_reg[0]  <= prod[W+18:19];
                    state_reg <= S_BW2;
                end
                S_BW2:
                begin
                    w_reg[1]  <= prod[W+18:19];
                    state_reg <= S_BW3;
                end
                S_BW3:
                begin
                    w_reg[2]  <= prod[W+18:19];
                    w_reg[3]  <= 18'sh10000 - w_reg[0] - w_reg[1] - $signed(prod[W+18:19]);
                    state_reg <= S_TAP;
                end
                S_TAP:
                begin
                    if (ram_re)
                        k_reg <= k_reg + 3'd1;
                    v1_reg <= ram_re;
                    k1_reg <= k_reg;
                    v2_reg <= v1_reg;
                    if (!ram_re && !v1_reg && !v2_reg)
                        state_reg <= S_RND;
                end
                S_RND:
                begin
                    if (rsp_free)
                    begin
                        out_value_reg <= oor_reg ? 16'sd0 : sat;
                        out_oor_reg   <= oor_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_value    = out_value_reg;
    assign rsp.out_of_range = out_oor_reg;

    trs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .acc   (acc)
    );

    trs_ram #(
        .WIDTH (trs_pkg::SAMPLE_W),
        .DEPTH (TRACE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.sample_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // out-of-range words always carry zero
    `TRS_ASSERT(a_oor_zero, clk, rst_n, (out_valid_reg && out_oor_reg) |-> (out_value_reg == 0))
    // tap counter stays within the kernel length
    `TRS_ASSERT(a_tap_bound, clk, rst_n, (state_reg == S_TAP) |-> (k_reg <= tap_n_reg))
    // a read request starts the position step next cycle
    `TRS_ASSERT(a_read_start, clk, rst_n, (req_acc && req.req_type) |=> (state_reg == S_POS))
    // no store read outside the tap phase
    `TRS_NEVER(a_read_phase, clk, rst_n, ram_re && (state_reg != S_TAP))

endmodule
